>>> src/lcts_pkg.sv
package lcts_pkg;

  localparam int SENSORS_DEF      = 4;
  localparam int TARE_REPEATS_DEF = 8;

  localparam int SAMPLE_W = 24;
  localparam int WEIGHT_W = 25;
  localparam int STATUS_W = 3;
  localparam int DIFF_W   = 25;

  localparam logic [1:0] CMD_MEASURE   = 2'd0;
  localparam logic [1:0] CMD_TARE      = 2'd1;
  localparam logic [1:0] CMD_CALIBRATE = 2'd2;
  localparam logic [1:0] CMD_LOAD      = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TARE_RUN  = 3'd1;
  localparam logic [2:0] ST_TARE_DONE = 3'd2;
  localparam logic [2:0] ST_DIV0      = 3'd3;
  localparam logic [2:0] ST_BAD_INDEX = 3'd4;

  typedef struct packed {
    logic [1:0]          command;
    logic [2:0]          sensor;
    logic signed [23:0]  raw_sample;
    logic signed [23:0]  value;
  } req_t;

  typedef struct packed {
    logic [2:0]  sensor_out;
    logic [24:0] weight;
    logic        changed;
    logic [2:0]  status;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture request, start divide if needed
    logic finish;    // commit state, build response
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_div;
    logic div_done;
  } dp_stat_t;

endpackage

>>> src/lcts_if.sv
interface lcts_req_if;
  logic          valid;
  logic          ready;
  lcts_pkg::req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface lcts_rsp_if;
  logic          valid;
  logic          ready;
  lcts_pkg::rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> src/lcts_div.sv
// signed restoring divider, one quotient bit per cycle, truncates toward zero
module lcts_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [24:0] dividend,
  input  logic signed [23:0] divisor,
  output logic               done,
  output logic signed [25:0] quotient
);
  localparam int N = 25;

  logic [24:0] rem_q;
  logic [24:0] quo_q;
  logic [23:0] den_q;
  logic        neg_q;
  logic [4:0]  cnt;
  logic        busy;
  logic [25:0] trial;
  logic [24:0] shifted;

  always_comb begin
    shifted = {rem_q[23:0], quo_q[24]};
    trial   = {1'b0, shifted} - {2'b00, den_q};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= 5'(N);
        rem_q <= '0;
        quo_q <= dividend[24] ? 25'(-dividend) : 25'(dividend);
        den_q <= divisor[23] ? 24'(-divisor) : 24'(divisor);
        neg_q <= dividend[24] ^ divisor[23];
      end else if (busy) begin
        if (!trial[25]) begin
          rem_q <= trial[24:0];
          quo_q <= {quo_q[23:0], 1'b1};
        end else begin
          rem_q <= shifted;
          quo_q <= {quo_q[23:0], 1'b0};
        end
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

endmodule

>>> src/lcts_datapath.sv
module lcts_datapath #(
  parameter int SENSORS      = lcts_pkg::SENSORS_DEF,
  parameter int TARE_REPEATS = lcts_pkg::TARE_REPEATS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [23:0]        deadband,
  input  lcts_pkg::req_t     req,
  input  lcts_pkg::dp_cmd_t  cmd,
  output lcts_pkg::dp_stat_t stat,
  output lcts_pkg::rsp_t     rsp
);
  localparam int IDX_W = (SENSORS > 1) ? $clog2(SENSORS) : 1;

  logic signed [23:0] offset_store [SENSORS];
  logic signed [23:0] scale_store  [SENSORS];
  logic [24:0]        last_weight  [SENSORS];
  logic signed [23:0] tare_average;
  logic [7:0]         tare_count;
  logic [2:0]         tare_sensor;
  logic               tare_active;

  lcts_pkg::req_t     r;
  logic               bad;
  logic [IDX_W-1:0]   idx;
  logic signed [23:0] divisor;
  logic               div_done;
  logic signed [25:0] quot;

  assign bad = ({1'b0, req.sensor} >= 4'(SENSORS));
  assign idx = r.sensor[IDX_W-1:0];

  always_comb begin
    stat.div_done = div_done;
    stat.need_div = 1'b0;
    if (!bad) begin
      if (req.command == lcts_pkg::CMD_MEASURE)
        stat.need_div = (scale_store[req.sensor[IDX_W-1:0]] != 24'sd0);
      else if (req.command == lcts_pkg::CMD_CALIBRATE)
        stat.need_div = (req.value != 24'sd0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r       <= req;
      divisor <= (req.command == lcts_pkg::CMD_MEASURE)
                 ? scale_store[req.sensor[IDX_W-1:0]] : req.value;
    end
  end

  lcts_div u_div (
    .clk(clk), .rst(rst), .start(cmd.load && stat.need_div),
    .dividend(25'(req.raw_sample) - 25'(offset_store[req.sensor[IDX_W-1:0]])),
    .divisor((req.command == lcts_pkg::CMD_MEASURE)
             ? scale_store[req.sensor[IDX_W-1:0]] : req.value),
    .done(div_done), .quotient(quot)
  );

  logic               rbad;
  logic signed [24:0] tsum;
  logic [25:0]        dw;
  logic [25:0]        adw;
  assign rbad = ({1'b0, r.sensor} >= 4'(SENSORS));
  assign tsum = 25'(tare_average) + 25'(r.raw_sample);
  assign dw   = 26'(quot) - {1'b0, last_weight[idx]};
  assign adw  = dw[25] ? -dw : dw;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SENSORS; i++) begin
        offset_store[i] <= '0;
        scale_store[i]  <= 24'sd1;
        last_weight[i]  <= '0;
      end
      tare_average <= '0;
      tare_count   <= '0;
      tare_sensor  <= '0;
      tare_active  <= 1'b0;
    end else if (cmd.finish) begin
      rsp.sensor_out <= r.sensor;
      rsp.changed    <= 1'b0;
      rsp.status     <= lcts_pkg::ST_OK;
      rsp.weight     <= '0;
      if (rbad) begin
        rsp.status <= lcts_pkg::ST_BAD_INDEX;
      end else begin
        rsp.weight <= last_weight[idx];
        case (r.command)
          lcts_pkg::CMD_MEASURE: begin
            if (divisor == 24'sd0) begin
              rsp.status <= lcts_pkg::ST_DIV0;
            end else if (!quot[25]) begin
              if (adw > {2'b00, deadband}) begin
                last_weight[idx] <= quot[24:0];
                rsp.weight       <= quot[24:0];
                rsp.changed      <= 1'b1;
              end
            end else if (last_weight[idx] != '0) begin
              last_weight[idx] <= '0;
              rsp.weight       <= '0;
              rsp.changed      <= 1'b1;
            end
          end
          lcts_pkg::CMD_TARE: begin
            logic signed [23:0] avg;
            logic [7:0]         cntn;
            if (!tare_active || tare_sensor != r.sensor) begin
              avg  = r.raw_sample;
              cntn = '0;
            end else begin
              avg  = 24'((tsum + 25'(tsum[24])) >>> 1);
              cntn = tare_count + 8'd1;
            end
            tare_sensor  <= r.sensor;
            tare_average <= avg;
            if (cntn >= 8'(TARE_REPEATS)) begin
              offset_store[idx] <= avg;
              tare_active <= 1'b0;
              tare_count  <= '0;
              rsp.status  <= lcts_pkg::ST_TARE_DONE;
            end else begin
              tare_active <= 1'b1;
              tare_count  <= cntn;
              rsp.status  <= lcts_pkg::ST_TARE_RUN;
            end
          end
          lcts_pkg::CMD_CALIBRATE: begin
            if (divisor == 24'sd0)
              rsp.status <= lcts_pkg::ST_DIV0;
            else if (quot > 26'sd8388607)
              scale_store[idx] <= 24'sd8388607;
            else if (quot < -26'sd8388608)
              scale_store[idx] <= -24'sd8388608;
            else
              scale_store[idx] <= quot[23:0];
          end
          default: begin
            scale_store[idx] <= r.value;
          end
        endcase
      end
    end
  end

endmodule

>>> src/lcts_ctrl.sv
module lcts_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output lcts_pkg::dp_cmd_t  cmd,
  input  lcts_pkg::dp_stat_t stat
);
  typedef enum logic [1:0] {IDLE, DIVIDE, COMMIT} state_t;
  state_t state;

  assign in_ready   = (state == IDLE) && (!out_valid || out_ready);
  assign cmd.load   = in_valid && in_ready;
  assign cmd.finish = (state == COMMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        IDLE: if (cmd.load) state <= stat.need_div ? DIVIDE : COMMIT;
        DIVIDE: if (stat.div_done) state <= COMMIT;
        COMMIT: begin
          state     <= IDLE;
          out_valid <= 1'b1;
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != IDLE) |-> !in_ready) else $error("accept while busy");
  a_commit_then_valid: assert property (@(posedge clk) disable iff (rst)
    (state == COMMIT) |=> out_valid) else $error("result lost");
  a_load_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state != IDLE)) else $error("request dropped");
endmodule

>>> src/load_cell_tare_scale_deadband_unit.sv
// channel    dir  payload
// req        in   command, sensor, raw_sample, value
// rsp        out  sensor_out, weight, changed, status
// deadband   in   cfg write, 24 bit
// measure and calibrate with a non-zero divisor: the request is captured, the
// bit-serial divider runs while the sequencer waits in DIVIDE, then COMMIT
// registers the result and raises valid; zero divisor, tare, load scale and bad
// index skip the divider and go from IDLE straight to COMMIT
// one request at a time; a new one is taken once the prior result is gone
// or being taken in the same cycle; rst is synchronous: offsets 0, scales 1,
// weights 0, tare idle
module load_cell_tare_scale_deadband_unit #(
  parameter int SENSORS      = lcts_pkg::SENSORS_DEF,
  parameter int TARE_REPEATS = lcts_pkg::TARE_REPEATS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  lcts_req_if.sink    req,
  lcts_rsp_if.source  rsp,
  input  logic        cfg_we,
  input  logic [23:0] cfg_wdata
);
  lcts_pkg::dp_cmd_t  cmd;
  lcts_pkg::dp_stat_t stat;
  logic [23:0]        deadband;

  // deadband register
  always_ff @(posedge clk) begin
    if (rst) deadband <= '0;
    else if (cfg_we) deadband <= cfg_wdata;
  end

  // sequencer
  lcts_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .cmd(cmd), .stat(stat)
  );

  // state stores, divider and result register
  lcts_datapath #(.SENSORS(SENSORS), .TARE_REPEATS(TARE_REPEATS)) u_dp (
    .clk(clk), .rst(rst), .deadband(deadband),
    .req(req.payload), .cmd(cmd), .stat(stat), .rsp(rsp.payload)
  );
endmodule
